/* hw/rtl/lspq_pkg.sv */
// shared types and codes for the linear scan priority queue
package lspq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_DEPTH       = 256;
  localparam int unsigned SLOT_W          = $clog2(MAX_DEPTH);
  localparam int unsigned ID_W            = 16;
  localparam int unsigned PRI_W           = 8;
  localparam int unsigned OCC_W           = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // running minimum handed from cell to cell during a scan
  typedef struct packed {
    logic              found;
    logic [PRI_W-1:0]  pri;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] idx;
  } carry_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic              wr_en;
    logic              shift_en;
    logic [SLOT_W-1:0] idx;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
  } cell_ctrl_t;

endpackage

/* hw/rtl/lspq_cell.sv */
// one queue slot: holds an entry and passes the running minimum to its neighbour
module lspq_cell
  import lspq_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned INDEX = 0,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] count,
  input  carry_t           carry_in,
  input  logic [ID_W-1:0]  nbr_id,
  input  logic [PRI_W-1:0] nbr_pri,
  output logic [ID_W-1:0]  slot_id,
  output logic [PRI_W-1:0] slot_pri,
  output carry_t           carry_out
);

  localparam logic [CNT_W-1:0]  MY_CNT = CNT_W'(INDEX);
  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

  logic   held;
  carry_t carry_next;

  assign held = MY_CNT < count;

  // strict less-than keeps the earliest entry on a tie
  always_comb begin
    carry_next = carry_in;
    if (held && (!carry_in.found || slot_pri < carry_in.pri)) begin
      carry_next.found = 1'b1;
      carry_next.pri   = slot_pri;
      carry_next.id    = slot_id;
      carry_next.idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.found <= 1'b0;
    end else begin
      carry_out.found <= carry_next.found;
    end
    carry_out.pri <= carry_next.pri;
    carry_out.id  <= carry_next.id;
    carry_out.idx <= carry_next.idx;
  end

  // close up behind a removed entry, or take the new tail entry
  always_ff @(posedge clk) begin
    priority if (ctrl.shift_en && ctrl.idx <= MY_IDX) begin
      slot_id  <= nbr_id;
      slot_pri <= nbr_pri;
    end else if (ctrl.wr_en && count == MY_CNT) begin
      slot_id  <= ctrl.id;
      slot_pri <= ctrl.pri;
    end
  end

endmodule

/* hw/rtl/linear_scan_priority_queue_top.sv */
// top level of the linear scan priority queue: sequencer and chain of slot cells
//
//  channel  | handshake             | fields
//  ---------+-----------------------+------------------------------------------
//  command  | start, busy           | command, entry_id, entry_priority
//  result   | done (one-cycle beat) | status, out_id, out_priority,
//           |                       | occupancy, now_empty
//
// a beat on the command side is taken at an edge with start high and busy low
// enqueue and any rejected or empty command: result beat in the next cycle
// dequeue on a non-empty queue: the minimum ripples through all DEPTH cells,
// one cell a cycle, and the result beat comes as the scan ends
// busy is high for the whole of that ripple; results cannot be held off
// synchronous reset empties the queue; slot contents are left as they are
module linear_scan_priority_queue_top
  import lspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             command,
  input  logic [ID_W-1:0]  entry_id,
  input  logic [PRI_W-1:0] entry_priority,
  output logic             done,
  output logic [1:0]       status,
  output logic [ID_W-1:0]  out_id,
  output logic [PRI_W-1:0] out_priority,
  output logic [OCC_W-1:0] occupancy,
  output logic             now_empty
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_cnt;

  logic             accept;
  logic             is_deq;
  logic             scan_last;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W+OCC_W-1:0] occ_wide;
  cell_ctrl_t       ctrl;
  carry_t           seed;

  carry_t           carry    [QUEUE_DEPTH];
  logic [ID_W-1:0]  slot_id  [QUEUE_DEPTH];
  logic [PRI_W-1:0] slot_pri [QUEUE_DEPTH];

  assign busy      = (state == SCAN);
  assign accept    = start && !busy;
  assign is_deq    = (command == CMD_DEQ);
  assign scan_last = (scan_cnt == LAST_IDX);
  assign count_dec = count - CNT_W'(1);

  // scan starts with nothing found; cells past the count just pass it on
  always_comb begin
    seed       = '0;
    seed.found = 1'b0;
  end

  always_comb begin
    ctrl.wr_en    = accept && !is_deq && (count < FULL_CNT);
    ctrl.shift_en = (state == SCAN) && scan_last;
    ctrl.idx      = carry[QUEUE_DEPTH-1].idx;
    ctrl.id       = entry_id;
    ctrl.pri      = entry_priority;
  end

  // the chain of slots, minimum flowing from slot 0 towards the tail
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    carry_t           c_in;
    logic [ID_W-1:0]  n_id;
    logic [PRI_W-1:0] n_pri;

    if (i == 0) begin : g_head
      assign c_in = seed;
    end else begin : g_body
      assign c_in = carry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign n_id  = slot_id[i];
      assign n_pri = slot_pri[i];
    end else begin : g_mid
      assign n_id  = slot_id[i+1];
      assign n_pri = slot_pri[i+1];
    end

    lspq_cell #(
      .DEPTH (QUEUE_DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (count),
      .carry_in  (c_in),
      .nbr_id    (n_id),
      .nbr_pri   (n_pri),
      .slot_id   (slot_id[i]),
      .slot_pri  (slot_pri[i]),
      .carry_out (carry[i])
    );
  end

  // occupancy reports the count cut to five bits
  logic [CNT_W-1:0] count_after;
  always_comb begin
    priority if (state == SCAN) begin
      count_after = count_dec;
    end else if (ctrl.wr_en) begin
      count_after = count + CNT_W'(1);
    end else begin
      count_after = count;
    end
  end
  assign occ_wide = {{OCC_W{1'b0}}, count_after};

  // sequencer: command decode, scan timing and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      scan_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            out_id       <= '0;
            out_priority <= '0;
            occupancy    <= occ_wide[OCC_W-1:0];
            now_empty    <= (count_after == '0);
            priority if (!is_deq) begin
              done   <= 1'b1;
              count  <= count_after;
              status <= ctrl.wr_en ? ST_ENQ : ST_FULL;
            end else if (count == '0) begin
              done   <= 1'b1;
              status <= ST_EMPTY;
            end else begin
              state    <= SCAN;
              scan_cnt <= '0;
            end
          end
        end
        SCAN: begin
          scan_cnt <= scan_cnt + IDX_W'(1);
          if (scan_last) begin
            state        <= IDLE;
            done         <= 1'b1;
            count        <= count_after;
            status       <= ST_DEQ;
            out_id       <= carry[QUEUE_DEPTH-1].id;
            out_priority <= carry[QUEUE_DEPTH-1].pri;
            occupancy    <= occ_wide[OCC_W-1:0];
            now_empty    <= (count_after == '0);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a dequeue on a held entry starts a scan, anything else answers at once
  a_cmd_path: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done != busy))
    else $error("command neither answered nor scanning");

  // a scan always ends with a dequeued entry and a smaller count
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && scan_last) |=> (done && status == ST_DEQ
                                       && count == $past(count) - CNT_W'(1)))
    else $error("scan ended without a dequeue");

  // a reject only happens on a full queue
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == FULL_CNT))
    else $error("entry rejected while space was left");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond queue depth");
`endif

endmodule

/* dv/tb_linear_scan_priority_queue_top.sv */
// self-checking testbench for the linear scan priority queue top level
module tb_linear_scan_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lspq_pkg::*;

  localparam int unsigned DEPTH         = QUEUE_DEPTH_DEF;
  localparam int unsigned DIRECTED_ROWS = 26;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned MAX_GAP       = 18;
  // slowest correct run is about 876 beats, each with the longest idle gap
  // and a full ripple, so this leaves plenty of room
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // one result beat as the queue should report it
  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [OCC_W-1:0] occ;
    logic             empty;
  } outcome_t;

  // one command beat; fixed rows carry a hand-written expectation
  typedef struct packed {
    command_t         cmd;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic             fixed;
    outcome_t         want;
  } step_t;

  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             start          = 1'b0;
  logic             command        = CMD_ENQ;
  logic [ID_W-1:0]  entry_id       = '0;
  logic [PRI_W-1:0] entry_priority = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [ID_W-1:0]  out_id;
  logic [PRI_W-1:0] out_priority;
  logic [OCC_W-1:0] occupancy;
  logic             now_empty;

  linear_scan_priority_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .entry_id      (entry_id),
    .entry_priority(entry_priority),
    .done          (done),
    .status        (status),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .occupancy     (occupancy),
    .now_empty     (now_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the queue contents, in insertion order
  logic [ID_W-1:0]  held_ids [DEPTH];
  logic [PRI_W-1:0] held_pris[DEPTH];
  int unsigned      held = 0;

  outcome_t    pending_results[$];
  int unsigned failures    = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;  // when set, command beats go back to back
  bit          filling     = 1'b1;  // random mix leans towards enqueue while set
  step_t       plan[DIRECTED_ROWS];

  // apply one command to the shadow queue and return the beat it should cause
  function automatic outcome_t serve_command(command_t cmd, logic [ID_W-1:0] id,
                                             logic [PRI_W-1:0] pri);
    outcome_t    o;
    int unsigned best;
    o = '{status: ST_ENQ, id: '0, pri: '0, occ: '0, empty: 1'b0};
    if (cmd == CMD_ENQ) begin
      if (held >= DEPTH) begin
        // full: entry dropped, contents untouched
        o.status = ST_FULL;
      end else begin
        held_ids[held]  = id;
        held_pris[held] = pri;
        held++;
        o.status = ST_ENQ;
      end
    end else if (held == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // strict less-than keeps the earliest of equal priorities
      best = 0;
      for (int unsigned i = 1; i < held; i++) begin
        if (held_pris[i] < held_pris[best]) best = i;
      end
      o.id  = held_ids[best];
      o.pri = held_pris[best];
      // entries behind the winner close up
      for (int unsigned i = best; i + 1 < held; i++) begin
        held_ids[i]  = held_ids[i + 1];
        held_pris[i] = held_pris[i + 1];
      end
      held--;
      o.status = ST_DEQ;
    end
    o.occ   = OCC_W'(held);
    o.empty = (held == 0);
    return o;
  endfunction

  function automatic step_t free_row(command_t cmd, logic [ID_W-1:0] id,
                                     logic [PRI_W-1:0] pri);
    step_t s;
    s       = '0;
    s.cmd   = cmd;
    s.id    = id;
    s.pri   = pri;
    s.fixed = 1'b0;
    return s;
  endfunction

  function automatic step_t known_row(command_t cmd, logic [ID_W-1:0] id,
                                      logic [PRI_W-1:0] pri, status_t st,
                                      logic [ID_W-1:0] oid, logic [PRI_W-1:0] opri,
                                      int unsigned occ, logic emp);
    step_t s;
    s       = free_row(cmd, id, pri);
    s.fixed = 1'b1;
    s.want  = '{status: st, id: oid, pri: opri, occ: OCC_W'(occ), empty: emp};
    return s;
  endfunction

  // random beat: long fill and drain runs so full and empty are reached often,
  // with some noise mixed in
  function automatic step_t draw_random_step();
    command_t         cmd;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    if (filling && held == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
    else if (!filling && held == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    if ($urandom_range(0, 9) == 0)
      cmd = $urandom_range(0, 1) ? CMD_DEQ : CMD_ENQ;
    else if (filling)
      cmd = ($urandom_range(0, 9) < 8) ? CMD_ENQ : CMD_DEQ;
    else
      cmd = ($urandom_range(0, 9) < 8) ? CMD_DEQ : CMD_ENQ;
    case ($urandom_range(0, 3))
      0:       pri = PRI_W'($urandom_range(0, 3));      // crowded, many ties
      1:       pri = PRI_W'($urandom_range(0, 255));
      2:       pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: pri = PRI_W'($urandom_range(120, 127));
    endcase
    case ($urandom_range(0, 7))
      0:       id = '0;
      1:       id = '1;
      default: id = ID_W'($urandom_range(0, 65535));
    endcase
    return free_row(cmd, id, pri);
  endfunction

  // present one command beat, hold it until taken, then record what it should yield
  task automatic issue(step_t s);
    int unsigned gap;
    outcome_t    o;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    command        <= s.cmd;
    entry_id       <= s.id;
    entry_priority <= s.pri;
    // busy as it stood just before this edge decides whether the beat is taken
    do @(posedge clk); while (busy);
    o = serve_command(s.cmd, s.id, s.pri);
    if (s.fixed) o = s.want;
    pending_results.push_back(o);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  // result side: every done beat is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d id %0d",
                 $time, status, out_id);
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status",       32'(want.status), 32'(status));
        compare_field("out_id",       32'(want.id),     32'(out_id));
        compare_field("out_priority", 32'(want.pri),    32'(out_priority));
        compare_field("occupancy",    32'(want.occ),    32'(occupancy));
        compare_field("now_empty",    32'(want.empty),  32'(now_empty));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // directed table
    // empty queue straight after reset
    plan[0] = known_row(CMD_DEQ, 16'h0000, 8'h00, ST_EMPTY, '0, '0, 0, 1'b1);
    // extremes of id and priority go in and come out lowest first
    plan[1] = known_row(CMD_ENQ, 16'hFFFF, 8'hFF, ST_ENQ, '0, '0, 1, 1'b0);
    plan[2] = known_row(CMD_ENQ, 16'h0000, 8'h00, ST_ENQ, '0, '0, 2, 1'b0);
    // id and priority fields are ignored on a dequeue
    plan[3] = known_row(CMD_DEQ, 16'hFFFF, 8'hFF, ST_DEQ, 16'h0000, 8'h00, 1, 1'b0);
    plan[4] = known_row(CMD_DEQ, 16'h0000, 8'h00, ST_DEQ, 16'hFFFF, 8'hFF, 0, 1'b1);
    plan[5] = known_row(CMD_DEQ, 16'hFFFF, 8'hFF, ST_EMPTY, '0, '0, 0, 1'b1);
    // fill every slot; slots 2, 7 and 12 tie on the lowest priority
    for (int unsigned i = 0; i < DEPTH; i++) begin
      plan[6 + i] = free_row(CMD_ENQ, 16'hA500 + ID_W'(i),
                             (i % 5 == 2) ? 8'h20 : 8'hF0 - PRI_W'(i));
    end
    // rejected while full; its priority would win if it had been stored
    plan[22] = known_row(CMD_ENQ, 16'h5A5A, 8'h00, ST_FULL, '0, '0, 16, 1'b0);
    // ties come out in insertion order, from the middle of the queue
    plan[23] = free_row(CMD_DEQ, 16'h0000, 8'h00);
    plan[24] = free_row(CMD_DEQ, 16'h0000, 8'h00);
    plan[25] = free_row(CMD_DEQ, 16'h0000, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned r = 0; r < DIRECTED_ROWS; r++) issue(plan[r]);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // stretches of back-to-back beats between stretches of random gaps
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      issue(draw_random_step());
    end
    start <= 1'b0;

    // drain, then give a late stray beat time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lspq_pkg.sv
hw/rtl/lspq_cell.sv
hw/rtl/linear_scan_priority_queue_top.sv
dv/tb_linear_scan_priority_queue_top.sv
